@@ design/snms_pkg.sv @@
// ----------------------------------------------------------------------------
// snms_pkg
// Shared types, constants and exp tables of the soft NMS block.
// ----------------------------------------------------------------------------
package snms_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int FQ_DEPTH    = 4;
    localparam int FQ_AW       = 2;
    localparam int OQ_DEPTH    = 2;
    localparam int DIV_DVD_W   = 48;
    localparam int DIV_DVS_W   = 33;
    localparam int DIV_CNT_W   = 6;
    localparam int EXP_INT_MAX = 12;

    localparam logic [15:0] RST_OVERLAP = 16'd19661;
    localparam logic [1:0]  RST_MODE    = 2'd2;
    localparam logic [15:0] RST_SIGMA   = 16'd2048;
    localparam logic [15:0] RST_FLOOR   = 16'd66;
    localparam logic [6:0]  RST_KEEP    = 7'd64;

    localparam logic [2:0] REG_OVERLAP = 3'd0;
    localparam logic [2:0] REG_MODE    = 3'd1;
    localparam logic [2:0] REG_SIGMA   = 3'd2;
    localparam logic [2:0] REG_FLOOR   = 3'd3;
    localparam logic [2:0] REG_KEEP    = 3'd4;

    localparam logic [1:0] MODE_HARD   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_GAUSS  = 2'd2;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] confidence;
        logic [7:0]  class_id;
        logic        final_box;
    } box_t;

    typedef struct packed {
        logic [15:0] out_left;
        logic [15:0] out_top;
        logic [15:0] out_right;
        logic [15:0] out_bottom;
        logic [15:0] out_confidence;
        logic [7:0]  out_class;
        logic [5:0]  origin_index;
        logic        run_end;
    } result_t;

    typedef struct packed {
        box_t        box;
        logic [31:0] area;
    } load_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [7:0]  label;
        logic [31:0] area;
        logic [5:0]  index;
    } entry_t;

    typedef struct packed {
        logic [15:0] overlap_threshold;
        logic [1:0]  suppress_mode;
        logic [15:0] gauss_sigma;
        logic [15:0] score_floor;
        logic [6:0]  keep_limit;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEL, ST_SCAN, ST_SWAP_A, ST_SWAP_B, ST_NEXT, ST_RD, ST_LOAD,
        ST_OVL, ST_INTER, ST_UNION, ST_IOU_DIV, ST_APPLY, ST_LIN, ST_G_SQ,
        ST_G_DIV, ST_G_FRAC, ST_G_EXP, ST_G_SCALE, ST_G_DONE, ST_FLOOR,
        ST_MOVE_RD, ST_MOVE_LD, ST_OUT_RD, ST_OUT_WR
    } nms_state_t;

    // exp(-k/16) in Q16
    function automatic logic [16:0] exp_frac(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-n) in Q16
    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/multilabel_soft_nms.sv @@
// ----------------------------------------------------------------------------
// multilabel_soft_nms
// Per-class soft non-maximum suppression over one set of detection boxes.
// ----------------------------------------------------------------------------
// Boxes enter through push/full; a box is taken when push is high and full
// low. Boxes are stored until one carries final_box, then the engine runs
// and the kept boxes come out through empty/pop in selection order, the last
// one flagged with run_end. An APB port holds the threshold, mode, sigma,
// floor and keep limit; write it only while the block is idle.
// Loading takes one box per cycle while the engine is idle. Each kept box
// costs a max scan over the remaining boxes, then a read of every later box,
// plus an IoU division when the label matches, a rescale step in linear mode
// when the overlap is over the threshold, and a second pass through the same
// divider in gaussian mode. The IoU and gaussian steps share one divider and
// the store has a single read port. Each result is read from the store in one
// state and pushed in the next. A 4-deep input queue fills while the engine works.
// Reset empties both queues and the set and restores register defaults; no
// clearing pass is needed. When the receiver stalls the 2-deep result queue
// fills and the engine holds until a pop frees space.
// ----------------------------------------------------------------------------
module multilabel_soft_nms #(
    parameter int MaxBoxes = snms_pkg::MAX_BOXES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  snms_pkg::box_t                    box,
    output logic                              empty,
    input  logic                              pop,
    output snms_pkg::result_t                 result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [snms_pkg::ADDR_W-1:0]       paddr,
    input  logic [snms_pkg::DATA_W-1:0]       pwdata,
    output logic [snms_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    snms_pkg::cfg_t  cfg_reg;
    snms_pkg::load_t ld;
    logic            ld_valid;
    logic            ld_pop;
    logic [2:0]      reg_idx;
    logic            wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[snms_pkg::ADDR_W-1:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlap_threshold <= snms_pkg::RST_OVERLAP;
            cfg_reg.suppress_mode     <= snms_pkg::RST_MODE;
            cfg_reg.gauss_sigma       <= snms_pkg::RST_SIGMA;
            cfg_reg.score_floor       <= snms_pkg::RST_FLOOR;
            cfg_reg.keep_limit        <= snms_pkg::RST_KEEP;
        end
        else if (wr)
        begin
            case (reg_idx)
                snms_pkg::REG_OVERLAP: cfg_reg.overlap_threshold <= pwdata[15:0];
                snms_pkg::REG_MODE:    cfg_reg.suppress_mode     <= pwdata[1:0];
                snms_pkg::REG_SIGMA:   cfg_reg.gauss_sigma       <= pwdata[15:0];
                snms_pkg::REG_FLOOR:   cfg_reg.score_floor       <= pwdata[15:0];
                snms_pkg::REG_KEEP:    cfg_reg.keep_limit        <= pwdata[6:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            snms_pkg::REG_OVERLAP: prdata = {16'd0, cfg_reg.overlap_threshold};
            snms_pkg::REG_MODE:    prdata = {30'd0, cfg_reg.suppress_mode};
            snms_pkg::REG_SIGMA:   prdata = {16'd0, cfg_reg.gauss_sigma};
            snms_pkg::REG_FLOOR:   prdata = {16'd0, cfg_reg.score_floor};
            snms_pkg::REG_KEEP:    prdata = {25'd0, cfg_reg.keep_limit};
            default:               prdata = '0;
        endcase
    end

    snms_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .box      (box),
        .ld_valid (ld_valid),
        .ld_pop   (ld_pop),
        .ld       (ld)
    );

    snms_back #(
        .MaxBoxes (MaxBoxes)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ld_valid (ld_valid),
        .ld_pop   (ld_pop),
        .ld       (ld),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

@@ design/snms_ram.sv @@
// ----------------------------------------------------------------------------
// snms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module snms_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/snms_front.sv @@
// ----------------------------------------------------------------------------
// snms_front
// Input side: takes boxes, computes the clamped area, queues them for the engine.
// ----------------------------------------------------------------------------
module snms_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  snms_pkg::box_t       box,
    output logic                 ld_valid,
    input  logic                 ld_pop,
    output snms_pkg::load_t      ld
);

    snms_pkg::load_t                 q_reg [snms_pkg::FQ_DEPTH];
    logic [snms_pkg::FQ_AW-1:0]      wp_reg, wp_next;
    logic [snms_pkg::FQ_AW-1:0]      rp_reg, rp_next;
    logic [snms_pkg::FQ_AW:0]        cnt_reg, cnt_next;
    logic                            acc;
    logic                            take;
    logic [15:0]                     w;
    logic [15:0]                     h;

    assign full     = (cnt_reg == (snms_pkg::FQ_AW + 1)'(snms_pkg::FQ_DEPTH));
    assign ld_valid = (cnt_reg != '0);
    assign acc      = push && !full;
    assign take     = ld_pop && ld_valid;
    assign ld       = q_reg[rp_reg];

    assign w = (box.right > box.left) ? (box.right - box.left) : 16'd0;
    assign h = (box.bottom > box.top) ? (box.bottom - box.top) : 16'd0;

    always_comb
    begin
        wp_next  = wp_reg + (snms_pkg::FQ_AW)'(acc);
        rp_next  = rp_reg + (snms_pkg::FQ_AW)'(take);
        cnt_next = cnt_reg + (snms_pkg::FQ_AW + 1)'(acc) - (snms_pkg::FQ_AW + 1)'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg].box  <= box;
            q_reg[wp_reg].area <= w * h;
        end
    end

endmodule

@@ design/snms_div.sv @@
// ----------------------------------------------------------------------------
// snms_div
// Restoring divider, one quotient bit per cycle, shared by IoU and gaussian.
// ----------------------------------------------------------------------------
module snms_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [snms_pkg::DIV_DVD_W-1:0]    dividend,
    input  logic [snms_pkg::DIV_DVS_W-1:0]    divisor,
    output logic                              busy,
    output logic                              done,
    output logic [snms_pkg::DIV_DVD_W-1:0]    quotient
);

    localparam int RW = snms_pkg::DIV_DVS_W + 1;

    logic [snms_pkg::DIV_DVD_W-1:0] dvd_reg;
    logic [snms_pkg::DIV_DVS_W-1:0] dvs_reg;
    logic [RW-1:0]                  rem_reg;
    logic [snms_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [RW-1:0]                  rem_sh;
    logic                           ge;

    assign rem_sh = {rem_reg[RW-2:0], dvd_reg[snms_pkg::DIV_DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == (snms_pkg::DIV_CNT_W)'(snms_pkg::DIV_DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[snms_pkg::DIV_DVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ design/snms_back.sv @@
// ----------------------------------------------------------------------------
// snms_back
// Suppression engine: box store, max scan, rescoring, removal, result queue.
// ----------------------------------------------------------------------------
module snms_back #(
    parameter int MaxBoxes = snms_pkg::MAX_BOXES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  snms_pkg::cfg_t       cfg,
    input  logic                 ld_valid,
    output logic                 ld_pop,
    input  snms_pkg::load_t      ld,
    output logic                 empty,
    input  logic                 pop,
    output snms_pkg::result_t    result
);

    localparam int AW = $clog2(MaxBoxes);
    localparam int CW = AW + 1;
    localparam int EW = $bits(snms_pkg::entry_t);
    localparam logic [CW-1:0] MaxCnt = CW'(MaxBoxes);

    snms_pkg::nms_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, n_reg, i_reg, pos_reg, issue_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_addr_reg, best_idx_reg;
    snms_pkg::entry_t best_reg, ient_reg, cur_reg;
    logic [15:0]   w_reg, h_reg, sc_reg;
    logic [33:0]   prod_reg;
    logic [16:0]   ovr_reg;

    // result queue
    snms_pkg::result_t oq_reg [snms_pkg::OQ_DEPTH];
    logic          oq_wp_reg, oq_rp_reg;
    logic [1:0]    oq_cnt_reg;
    logic          oq_push;
    snms_pkg::result_t oq_data;
    logic          oq_take;

    // store port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    snms_pkg::entry_t ram_wdata, rd;
    logic [EW-1:0] rd_bits;

    // arithmetic
    logic [16:0]   mul_a, mul_b;
    logic          div_start, div_busy, div_done;
    logic [snms_pkg::DIV_DVD_W-1:0] div_dvd, div_q;
    logic [snms_pkg::DIV_DVS_W-1:0] div_dvs;

    logic          cnt_lt;
    logic          sel_end;
    logic          label_hit;
    logic [15:0]   mn_r, mx_l, mn_b, mx_t;
    logic [16:0]   wx, hx;
    logic [32:0]   area_sum, union_w;
    logic [31:0]   inter;
    logic          no_union;
    logic          ovr_over;
    logic          g_big;
    logic [4:0]    g_k;
    logic [16:0]   g_fk, g_fk1, g_f;
    logic [15:0]   sig_eff;
    logic          below;
    logic          oq_space;

    assign cnt_lt    = (count_reg < MaxCnt);
    assign sel_end   = (i_reg == n_reg) || (cfg.keep_limit == 7'(i_reg));
    assign rd        = snms_pkg::entry_t'(rd_bits);
    assign label_hit = (rd.label == best_reg.label);

    assign mn_r = (best_reg.right < cur_reg.right) ? best_reg.right : cur_reg.right;
    assign mx_l = (best_reg.left > cur_reg.left) ? best_reg.left : cur_reg.left;
    assign mn_b = (best_reg.bottom < cur_reg.bottom) ? best_reg.bottom : cur_reg.bottom;
    assign mx_t = (best_reg.top > cur_reg.top) ? best_reg.top : cur_reg.top;
    assign wx   = {1'b0, mn_r} - {1'b0, mx_l};
    assign hx   = {1'b0, mn_b} - {1'b0, mx_t};

    assign area_sum = {1'b0, best_reg.area} + {1'b0, cur_reg.area};
    assign inter    = prod_reg[31:0];
    assign no_union = (area_sum <= {1'b0, inter});
    assign union_w  = area_sum - {1'b0, inter};
    assign ovr_over = (ovr_reg > {1'b0, cfg.overlap_threshold});

    assign g_big   = (div_q[snms_pkg::DIV_DVD_W-1:16] >=
                      (snms_pkg::DIV_DVD_W - 16)'(snms_pkg::EXP_INT_MAX));
    assign g_k     = {1'b0, div_q[15:12]};
    assign g_fk    = snms_pkg::exp_frac(g_k);
    assign g_fk1   = snms_pkg::exp_frac(g_k + 5'd1);
    assign g_f     = g_fk - 17'(prod_reg >> 12);
    assign sig_eff = (cfg.gauss_sigma == 16'd0) ? 16'd1 : cfg.gauss_sigma;

    assign below    = (sc_reg < cfg.score_floor);
    assign oq_space = (oq_cnt_reg != 2'(snms_pkg::OQ_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            snms_pkg::ST_IDLE:
                if (ld_valid && ld.box.final_box) state_next = snms_pkg::ST_SEL;
            snms_pkg::ST_SEL:
                state_next = sel_end ? snms_pkg::ST_OUT_RD : snms_pkg::ST_SCAN;
            snms_pkg::ST_SCAN:
                if (!pend_reg && (issue_reg >= n_reg)) state_next = snms_pkg::ST_SWAP_A;
            snms_pkg::ST_SWAP_A:  state_next = snms_pkg::ST_SWAP_B;
            snms_pkg::ST_SWAP_B:  state_next = snms_pkg::ST_NEXT;
            snms_pkg::ST_NEXT:
                state_next = (pos_reg < n_reg) ? snms_pkg::ST_RD : snms_pkg::ST_SEL;
            snms_pkg::ST_RD:      state_next = snms_pkg::ST_LOAD;
            snms_pkg::ST_LOAD,
            snms_pkg::ST_MOVE_LD:
                state_next = label_hit ? snms_pkg::ST_OVL : snms_pkg::ST_FLOOR;
            snms_pkg::ST_OVL:     state_next = snms_pkg::ST_INTER;
            snms_pkg::ST_INTER:   state_next = snms_pkg::ST_UNION;
            snms_pkg::ST_UNION:
                state_next = no_union ? snms_pkg::ST_APPLY : snms_pkg::ST_IOU_DIV;
            snms_pkg::ST_IOU_DIV:
                if (div_done) state_next = snms_pkg::ST_APPLY;
            snms_pkg::ST_APPLY:
                case (cfg.suppress_mode)
                    snms_pkg::MODE_LINEAR:
                        state_next = ovr_over ? snms_pkg::ST_LIN : snms_pkg::ST_FLOOR;
                    snms_pkg::MODE_GAUSS:
                        state_next = snms_pkg::ST_G_SQ;
                    default:
                        state_next = snms_pkg::ST_FLOOR;
                endcase
            snms_pkg::ST_LIN:     state_next = snms_pkg::ST_FLOOR;
            snms_pkg::ST_G_SQ:    state_next = snms_pkg::ST_G_DIV;
            snms_pkg::ST_G_DIV:
                if (div_done) state_next = snms_pkg::ST_G_FRAC;
            snms_pkg::ST_G_FRAC:
                state_next = g_big ? snms_pkg::ST_FLOOR : snms_pkg::ST_G_EXP;
            snms_pkg::ST_G_EXP:   state_next = snms_pkg::ST_G_SCALE;
            snms_pkg::ST_G_SCALE: state_next = snms_pkg::ST_G_DONE;
            snms_pkg::ST_G_DONE:  state_next = snms_pkg::ST_FLOOR;
            snms_pkg::ST_FLOOR:
                if (below && (pos_reg + 1'b1 < n_reg)) state_next = snms_pkg::ST_MOVE_RD;
                else                                   state_next = snms_pkg::ST_NEXT;
            snms_pkg::ST_MOVE_RD: state_next = snms_pkg::ST_MOVE_LD;
            snms_pkg::ST_OUT_RD:
                if (pos_reg == n_reg) state_next = snms_pkg::ST_IDLE;
                else if (oq_space)    state_next = snms_pkg::ST_OUT_WR;
            snms_pkg::ST_OUT_WR:  state_next = snms_pkg::ST_OUT_RD;
            default:              state_next = snms_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ld_pop    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = cur_reg;
        ram_raddr = '0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvd   = {inter, 16'd0};
        div_dvs   = union_w;
        oq_push   = 1'b0;
        oq_data   = '{out_left: rd.left, out_top: rd.top, out_right: rd.right,
                      out_bottom: rd.bottom, out_confidence: rd.score,
                      out_class: rd.label, origin_index: rd.index,
                      run_end: (pos_reg + 1'b1 == n_reg)};
        case (state_reg)
            snms_pkg::ST_IDLE:
            begin
                ld_pop    = ld_valid;
                ram_we    = ld_valid && cnt_lt;
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = '{left: ld.box.left, top: ld.box.top, right: ld.box.right,
                              bottom: ld.box.bottom, score: ld.box.confidence,
                              label: ld.box.class_id, area: ld.area,
                              index: 6'(7'(count_reg))};
            end
            snms_pkg::ST_SCAN:
                ram_raddr = issue_reg[AW-1:0];
            snms_pkg::ST_SWAP_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[AW-1:0];
                ram_wdata = best_reg;
            end
            snms_pkg::ST_SWAP_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = best_idx_reg;
                ram_wdata = ient_reg;
            end
            snms_pkg::ST_RD:
                ram_raddr = pos_reg[AW-1:0];
            snms_pkg::ST_MOVE_RD:
                ram_raddr = n_reg[AW-1:0];
            snms_pkg::ST_MOVE_LD:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = rd;
            end
            snms_pkg::ST_INTER:
            begin
                mul_a = {1'b0, w_reg};
                mul_b = {1'b0, h_reg};
            end
            snms_pkg::ST_UNION:
                div_start = !no_union;
            snms_pkg::ST_APPLY:
                case (cfg.suppress_mode)
                    snms_pkg::MODE_LINEAR:
                    begin
                        mul_a = {1'b0, sc_reg};
                        mul_b = 17'h10000 - ovr_reg;
                    end
                    snms_pkg::MODE_GAUSS:
                    begin
                        mul_a = ovr_reg;
                        mul_b = ovr_reg;
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            snms_pkg::ST_G_SQ:
            begin
                div_start = 1'b1;
                div_dvd   = {14'd0, prod_reg};
                div_dvs   = {13'd0, sig_eff, 4'd0};
            end
            snms_pkg::ST_G_FRAC:
            begin
                mul_a = g_fk - g_fk1;
                mul_b = {5'd0, div_q[11:0]};
            end
            snms_pkg::ST_G_EXP:
            begin
                mul_a = snms_pkg::exp_int(div_q[19:16]);
                mul_b = g_f;
            end
            snms_pkg::ST_G_SCALE:
            begin
                mul_a = prod_reg[32:16];
                mul_b = {1'b0, sc_reg};
            end
            snms_pkg::ST_FLOOR:
            begin
                ram_we          = !below;
                ram_waddr       = pos_reg[AW-1:0];
                ram_wdata       = cur_reg;
                ram_wdata.score = sc_reg;
            end
            snms_pkg::ST_OUT_RD:
                ram_raddr = pos_reg[AW-1:0];
            snms_pkg::ST_OUT_WR:
                oq_push = 1'b1;
            default:
                ld_pop = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= snms_pkg::ST_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            pos_reg   <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                snms_pkg::ST_IDLE:
                    if (ld_valid)
                    begin
                        if (ld.box.final_box)
                        begin
                            count_reg <= '0;
                            n_reg     <= count_reg + CW'(cnt_lt);
                            i_reg     <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(cnt_lt);
                        end
                    end
                snms_pkg::ST_SEL:
                    if (sel_end)
                    begin
                        n_reg   <= i_reg;
                        pos_reg <= '0;
                    end
                    else
                    begin
                        issue_reg <= i_reg;
                        pend_reg  <= 1'b0;
                    end
                snms_pkg::ST_SCAN:
                begin
                    pend_reg <= (issue_reg < n_reg);
                    if (issue_reg < n_reg) issue_reg <= issue_reg + 1'b1;
                end
                snms_pkg::ST_SWAP_B:
                    pos_reg <= i_reg + 1'b1;
                snms_pkg::ST_NEXT:
                    if (!(pos_reg < n_reg)) i_reg <= i_reg + 1'b1;
                snms_pkg::ST_FLOOR:
                    if (below) n_reg   <= n_reg - 1'b1;
                    else       pos_reg <= pos_reg + 1'b1;
                snms_pkg::ST_OUT_WR:
                    pos_reg <= pos_reg + 1'b1;
                default:
                    pend_reg <= pend_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            snms_pkg::ST_SCAN:
            begin
                pend_addr_reg <= issue_reg[AW-1:0];
                if (pend_reg)
                begin
                    if (pend_addr_reg == i_reg[AW-1:0])
                    begin
                        ient_reg     <= rd;
                        best_reg     <= rd;
                        best_idx_reg <= pend_addr_reg;
                    end
                    else if (best_reg.score < rd.score)
                    begin
                        best_reg     <= rd;
                        best_idx_reg <= pend_addr_reg;
                    end
                end
            end
            snms_pkg::ST_LOAD,
            snms_pkg::ST_MOVE_LD:
            begin
                cur_reg <= rd;
                sc_reg  <= rd.score;
            end
            snms_pkg::ST_OVL:
            begin
                w_reg <= wx[16] ? 16'd0 : wx[15:0];
                h_reg <= hx[16] ? 16'd0 : hx[15:0];
            end
            snms_pkg::ST_UNION:
                if (no_union) ovr_reg <= '0;
            snms_pkg::ST_IOU_DIV:
                if (div_done) ovr_reg <= div_q[16:0];
            snms_pkg::ST_APPLY:
                if ((cfg.suppress_mode != snms_pkg::MODE_LINEAR) &&
                    (cfg.suppress_mode != snms_pkg::MODE_GAUSS) && ovr_over)
                    sc_reg <= '0;
            snms_pkg::ST_LIN,
            snms_pkg::ST_G_DONE:
                sc_reg <= prod_reg[31:16];
            snms_pkg::ST_G_FRAC:
                if (g_big) sc_reg <= '0;
            default:
                sc_reg <= sc_reg;
        endcase
        if (oq_push)
        begin
            oq_reg[oq_wp_reg] <= oq_data;
        end
    end

    // result queue pointers
    assign oq_take = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push) oq_wp_reg <= !oq_wp_reg;
            if (oq_take) oq_rp_reg <= !oq_rp_reg;
            oq_cnt_reg <= oq_cnt_reg + 2'(oq_push) - 2'(oq_take);
        end
    end

    assign empty  = (oq_cnt_reg == 2'd0);
    assign result = oq_reg[oq_rp_reg];

    snms_ram #(
        .Width (EW),
        .Depth (MaxBoxes)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );

    snms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MaxCnt)
        else $error("box count beyond store depth");

    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> oq_cnt_reg != 2'(snms_pkg::OQ_DEPTH))
        else $error("result queue overrun");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == snms_pkg::ST_FLOOR) |-> (pos_reg < n_reg) && (i_reg < pos_reg))
        else $error("rescore position out of range");
`endif

endmodule

@@ test/snms_checker.sv @@
// ----------------------------------------------------------------------------
// snms_checker
// Watches the box, result and register channels of multilabel_soft_nms,
// predicts the kept boxes of each set and compares them field by field.
// ----------------------------------------------------------------------------
module snms_checker
    import snms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  box_t                box,
    input  logic                empty,
    input  logic                pop,
    input  result_t             result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FRAC_TAB [0:16] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313, 39750,
        37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};
    localparam logic [63:0] INT_TAB [0:11] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};

    // Extra slot at MAX_BOXES holds a box during a swap.
    cfg_t        cfg;
    logic [15:0] s_left [MAX_BOXES + 1];
    logic [15:0] s_top [MAX_BOXES + 1];
    logic [15:0] s_right [MAX_BOXES + 1];
    logic [15:0] s_bottom [MAX_BOXES + 1];
    logic [15:0] s_score [MAX_BOXES + 1];
    logic [7:0]  s_label [MAX_BOXES + 1];
    logic [31:0] s_area [MAX_BOXES + 1];
    logic [5:0]  s_index [MAX_BOXES + 1];
    int          set_size;
    result_t     kept_q[$];

    assign pending = kept_q.size();

    function automatic void move_box(int dst, int src);
        s_left[dst] = s_left[src];
        s_top[dst] = s_top[src];
        s_right[dst] = s_right[src];
        s_bottom[dst] = s_bottom[src];
        s_score[dst] = s_score[src];
        s_label[dst] = s_label[src];
        s_area[dst] = s_area[src];
        s_index[dst] = s_index[src];
    endfunction

    function automatic void swap_box(int a, int b);
        move_box(MAX_BOXES, a);
        move_box(a, b);
        move_box(b, MAX_BOXES);
    endfunction

    function automatic logic [63:0] overlap(int a, int b);
        int          w;
        int          h;
        logic [63:0] inter;
        logic [63:0] sum;
        w = int'(s_right[a] < s_right[b] ? s_right[a] : s_right[b])
            - int'(s_left[a] > s_left[b] ? s_left[a] : s_left[b]);
        h = int'(s_bottom[a] < s_bottom[b] ? s_bottom[a] : s_bottom[b])
            - int'(s_top[a] > s_top[b] ? s_top[a] : s_top[b]);
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        inter = 64'(w) * 64'(h);
        sum = 64'(s_area[a]) + 64'(s_area[b]);
        if (sum <= inter) return 64'd0;
        return (inter << 16) / (sum - inter);
    endfunction

    function automatic logic [63:0] gauss_weight(logic [63:0] ovr);
        logic [63:0] sig;
        logic [63:0] x;
        logic [63:0] n;
        logic [63:0] f;
        int          k;
        sig = (cfg.gauss_sigma == 0) ? 64'd1 : 64'(cfg.gauss_sigma);
        x = (ovr * ovr) / (sig * 64'd16);
        n = x >> 16;
        if (n >= 12) return 64'd0;
        k = int'(x[15:12]);
        f = FRAC_TAB[k] - (((FRAC_TAB[k] - FRAC_TAB[k + 1]) * 64'(x[11:0])) >> 12);
        return (INT_TAB[n] * f) >> 16;
    endfunction

    // Run the suppression over the stored set and queue the kept boxes.
    function automatic void suppress_set();
        int          n;
        int          i;
        int          best;
        int          pos;
        logic [63:0] ovr;
        logic [63:0] s;
        result_t     r;
        n = set_size;
        set_size = 0;
        for (i = 0; i < n; i++) begin
            if (int'(cfg.keep_limit) == i) begin
                n = i;
                break;
            end
            best = i;
            for (pos = i + 1; pos < n; pos++)
                if (s_score[best] < s_score[pos]) best = pos;
            if (best != i) swap_box(i, best);
            pos = i + 1;
            while (pos < n) begin
                if (s_label[pos] == s_label[i]) begin
                    ovr = overlap(i, pos);
                    s = 64'(s_score[pos]);
                    if (cfg.suppress_mode == MODE_LINEAR) begin
                        if (ovr > 64'(cfg.overlap_threshold)) s = (s * (64'd65536 - ovr)) >> 16;
                    end else if (cfg.suppress_mode == MODE_GAUSS) begin
                        s = (gauss_weight(ovr) * s) >> 16;
                    end else if (ovr > 64'(cfg.overlap_threshold)) begin
                        s = 64'd0;
                    end
                    s_score[pos] = s[15:0];
                end
                if (s_score[pos] < cfg.score_floor) begin
                    n--;
                    move_box(pos, n);
                end else begin
                    pos++;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            r.out_left = s_left[i];
            r.out_top = s_top[i];
            r.out_right = s_right[i];
            r.out_bottom = s_bottom[i];
            r.out_confidence = s_score[i];
            r.out_class = s_label[i];
            r.origin_index = s_index[i];
            r.run_end = (i + 1 == n);
            kept_q.push_back(r);
        end
    endfunction

    function automatic void load_box(box_t b);
        logic [31:0] w;
        logic [31:0] h;
        if (set_size < MAX_BOXES) begin
            w = (b.right > b.left) ? 32'(b.right - b.left) : 32'd0;
            h = (b.bottom > b.top) ? 32'(b.bottom - b.top) : 32'd0;
            s_left[set_size] = b.left;
            s_top[set_size] = b.top;
            s_right[set_size] = b.right;
            s_bottom[set_size] = b.bottom;
            s_score[set_size] = b.confidence;
            s_label[set_size] = b.class_id;
            s_area[set_size] = w * h;
            s_index[set_size] = 6'(set_size);
            set_size++;
        end
        if (b.final_box) suppress_set();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            cfg <= '{RST_OVERLAP, RST_MODE, RST_SIGMA, RST_FLOOR, RST_KEEP};
            set_size = 0;
            errors = 0;
            kept_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_OVERLAP: cfg.overlap_threshold <= pwdata[15:0];
                    REG_MODE:    cfg.suppress_mode <= pwdata[1:0];
                    REG_SIGMA:   cfg.gauss_sigma <= pwdata[15:0];
                    REG_FLOOR:   cfg.score_floor <= pwdata[15:0];
                    REG_KEEP:    cfg.keep_limit <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (push && !full) load_box(box);
            if (pop && !empty) begin
                if (kept_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", result);
                end else begin
                    want = kept_q.pop_front();
                    if (want !== result) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p, got %p", want, result);
                    end
                end
            end
        end
    end
endmodule

@@ test/tb_multilabel_soft_nms.sv @@
// ----------------------------------------------------------------------------
// tb_multilabel_soft_nms
// Drives sets of detection boxes through the soft NMS block under several
// register settings, with random stalls on both sides; the checker predicts
// and compares every kept box.
// ----------------------------------------------------------------------------
module tb_multilabel_soft_nms;
    import snms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 1000000;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    box_t              box;
    logic              empty;
    logic              pop;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    bit                calm;
    int                quiet;

    multilabel_soft_nms u_top (.*);

    snms_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: count cycles without any accepted request.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall in random bursts, never in the last part.
    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!calm && stall == 0 && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 4);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send(box_t b);
        int gap;
        push <= 1'b1;
        box <= b;
        do @(posedge clk); while (full);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold off until every kept box has drained and the engine is done.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic box_t mk(int l, int t, int r, int b, int s, int c, bit f);
        box_t x;
        x.left = 16'(l);
        x.top = 16'(t);
        x.right = 16'(r);
        x.bottom = 16'(b);
        x.confidence = 16'(s);
        x.class_id = 8'(c);
        x.final_box = f;
        return x;
    endfunction

    // Mostly clustered boxes so that overlaps happen; sometimes fully random.
    function automatic box_t rnd_box(int max_label, bit f);
        box_t        x;
        int          l;
        int          t;
        logic [95:0] raw;
        if ($urandom_range(0, 5) == 0) begin
            raw = {$urandom, $urandom, $urandom};
            x = raw[$bits(box_t)-1:0];
        end else begin
            l = $urandom_range(0, 1500);
            t = $urandom_range(0, 1500);
            x = mk(l, t, l + $urandom_range(0, 900) - 20, t + $urandom_range(0, 900) - 20,
                   $urandom_range(0, 65535), $urandom_range(0, max_label), 0);
        end
        x.final_box = f;
        return x;
    endfunction

    task automatic random_set(int size, int max_label);
        for (int i = 0; i < size; i++) send(rnd_box(max_label, i == size - 1));
    endtask

    task automatic phase(logic [15:0] thr, logic [1:0] mode, logic [15:0] sig,
                         logic [15:0] flr, logic [6:0] keep, int sets);
        write_reg(REG_OVERLAP, thr);
        write_reg(REG_MODE, mode);
        write_reg(REG_SIGMA, sig);
        write_reg(REG_FLOOR, flr);
        write_reg(REG_KEEP, keep);
        for (int i = 0; i < sets; i++) random_set($urandom_range(1, 8), 3);
        drain();
    endtask

    initial
    begin
        push <= 1'b0;
        box <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        calm = 0;
        quiet = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed set under reset values: extremes, ties, empty boxes.
        send(mk(0, 0, 65535, 65535, 65535, 0, 0));
        send(mk(0, 0, 65535, 65535, 65535, 0, 0));
        send(mk(100, 100, 50, 50, 0, 255, 0));
        send(mk(65535, 65535, 0, 0, 1000, 255, 0));
        send(mk(16, 16, 400, 400, 30000, 7, 0));
        send(mk(20, 20, 400, 400, 30000, 7, 0));
        send(mk(500, 500, 600, 600, 65, 7, 0));
        send(mk(0, 0, 0, 0, 0, 0, 1));
        // Single box set with zero score: first pick kept anyway.
        send(mk(3, 3, 9, 9, 0, 1, 1));
        drain();

        // Hard, linear, unknown and gaussian modes, zero sigma, extremes of every register.
        phase(16'd0, MODE_HARD, 16'd2048, 16'd0, 7'd64, 5);
        phase(16'd19661, MODE_LINEAR, 16'd2048, 16'd66, 7'd3, 5);
        phase(16'hFFFF, MODE_LINEAR, 16'd1, 16'hFFFF, 7'd1, 5);
        phase(16'd30000, 2'd3, 16'd2048, 16'd500, 7'd64, 5);
        phase(16'd19661, MODE_GAUSS, 16'd0, 16'd66, 7'd100, 5);
        phase(16'd19661, MODE_GAUSS, 16'hFFFF, 16'd0, 7'd127, 5);
        phase(16'd19661, MODE_GAUSS, 16'd512, 16'd2000, 7'd0, 4);

        // Overflow: 66 boxes, the last two dropped, the last still ends the set.
        write_reg(REG_KEEP, 7'd64);
        write_reg(REG_MODE, MODE_HARD);
        random_set(66, 255);
        drain();
        // Full set of few labels in gaussian mode.
        write_reg(REG_MODE, MODE_GAUSS);
        write_reg(REG_SIGMA, 16'd2048);
        random_set(64, 3);
        drain();

        for (int p = 0; p < 6; p++)
            phase(16'($urandom), 2'($urandom_range(0, 3)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(0, 4000)), 7'($urandom_range(1, 64)), 8);

        calm = 1;
        phase(16'd19661, MODE_GAUSS, 16'd2048, 16'd66, 7'd64, 12);

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ multilabel_soft_nms.f @@
design/snms_pkg.sv
design/snms_ram.sv
design/snms_front.sv
design/snms_div.sv
design/snms_back.sv
design/multilabel_soft_nms.sv
test/snms_checker.sv
test/tb_multilabel_soft_nms.sv
